[hw/rtl/binary_trie_xor_extremum_top_macros.svh]
`ifndef BINARY_TRIE_XOR_EXTREMUM_TOP_MACROS_SVH
`define BINARY_TRIE_XOR_EXTREMUM_TOP_MACROS_SVH
// Concurrent assertion helpers, clocked on clk_i, disabled in reset.
`define BTX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BTX_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`endif

[hw/rtl/btx_pkg.sv]
package btx_pkg;
  localparam int unsigned KeyBits   = 30;
  localparam int unsigned NodeBits  = 16;
  localparam int unsigned PoolNodes = 65536;
  localparam int unsigned CntBits   = 16;
  localparam int unsigned MaxKeys   = 65535;
  localparam int unsigned LvlBits   = 5;

  localparam logic [2:0] CmdInsert = 3'd0;
  localparam logic [2:0] CmdErase  = 3'd1;
  localparam logic [2:0] CmdCount  = 3'd2;
  localparam logic [2:0] CmdMax    = 3'd3;
  localparam logic [2:0] CmdMin    = 3'd4;
  localparam logic [2:0] CmdClear  = 3'd5;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StEmpty  = 2'd1;
  localparam logic [1:0] StNoRoom = 2'd2;
  localparam logic [1:0] StAbsent = 2'd3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [KeyBits-1:0] key;
  } req_t;

  typedef struct packed {
    logic [KeyBits-1:0] value;
    logic [CntBits-1:0] stored_keys;
    logic [1:0]         status;
  } rsp_t;
endpackage

[hw/rtl/binary_trie_xor_extremum_top.sv]
// Binary trie multiset of 30-bit keys with XOR max/min queries.
// Input channel req_valid_i/req_ready_o carries btx_pkg::req_t {cmd, key};
// output channel rsp_valid_o/rsp_ready_i carries btx_pkg::rsp_t
// {value, stored_keys, status}, one response per request, in order.
// One command is processed at a time: req_ready_o is high only while idle.
// The trie lives in one node memory (two 16-bit links plus a 16-bit pass
// count per entry, registered read); the root and the allocation pointer are
// flops. Insert walks down from the root, allocating a new node where a link
// is missing and updating the existing node otherwise; count is a find walk;
// erase is a find walk, then a decrement walk; max/min walk down level by
// level. Clear, no room, empty set and unused codes go straight to the response.
// Reset and clear need no memory sweep, since every node is written when it
// is allocated.
// The response sits in an output register. If the receiver stalls while a
// response is held, the next result waits in the block and intake stops.
module binary_trie_xor_extremum_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  btx_pkg::req_t   req_i,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output btx_pkg::rsp_t   rsp_o
);
  `include "binary_trie_xor_extremum_top_macros.svh"

  localparam int unsigned NB = btx_pkg::NodeBits;
  localparam int unsigned CB = btx_pkg::CntBits;
  localparam int unsigned KB = btx_pkg::KeyBits;
  localparam int unsigned LB = btx_pkg::LvlBits;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_FSTEP = 10'b0000000010,
    S_FLOAD = 10'b0000000100,
    S_STEP  = 10'b0000001000,
    S_LOAD  = 10'b0000010000,
    S_FIN   = 10'b0000100000,
    S_XSTEP = 10'b0001000000,
    S_XCHK  = 10'b0010000000,
    S_XLOAD = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic [NB-1:0] l0;
    logic [NB-1:0] l1;
    logic [CB-1:0] cnt;
  } node_t;

  node_t mem_q [btx_pkg::PoolNodes];
  node_t rd_q;
  logic  mem_we;
  logic [NB-1:0] mem_wa, mem_ra;
  node_t mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[mem_ra];
  end

  state_e state_q, state_d;
  logic [2:0]    cmd_q;
  logic [KB-1:0] key_q;
  logic [LB-1:0] lvl_q, lvl_d;
  logic [NB-1:0] node_q, node_d;
  node_t         cur_q, cur_d;
  logic          leaf_q, leaf_d;
  logic [NB:0]   nfree_q, nfree_d;
  logic [NB-1:0] root_l0_q, root_l0_d, root_l1_q, root_l1_d;
  logic [CB-1:0] root_cnt_q, root_cnt_d;
  logic [KB-1:0] acc_q, acc_d;
  logic [KB-1:0] val_q, val_d;
  logic [1:0]    st_q, st_d;
  logic          rsp_valid_q;
  btx_pkg::rsp_t rsp_q, rsp_d;
  logic          rsp_load;

  logic          bit_k, pref;
  logic [NB-1:0] lk_b, lk_p, lk_np, nxt;
  node_t         wr_node;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d = state_q; lvl_d = lvl_q; node_d = node_q; nfree_d = nfree_q;
    cur_d = cur_q; leaf_d = leaf_q;
    root_l0_d = root_l0_q; root_l1_d = root_l1_q; root_cnt_d = root_cnt_q;
    acc_d = acc_q; val_d = val_q; st_d = st_q;
    rsp_d = rsp_q; rsp_load = 1'b0;
    mem_we = 1'b0; mem_wa = node_q; mem_wd = cur_q; mem_ra = node_q;
    nxt = '0; wr_node = cur_q;
    bit_k = key_q[lvl_q];
    pref  = (cmd_q == btx_pkg::CmdMax) ? ~bit_k : bit_k;
    lk_b  = bit_k ? cur_q.l1 : cur_q.l0;
    lk_p  = pref ? cur_q.l1 : cur_q.l0;
    lk_np = pref ? cur_q.l0 : cur_q.l1;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          node_d = '0; lvl_d = LB'(KB - 1); acc_d = '0; val_d = '0;
          st_d = btx_pkg::StOk; leaf_d = 1'b0;
          cur_d = '{l0: root_l0_q, l1: root_l1_q, cnt: root_cnt_q};
          state_d = S_DONE;
          case (req_i.cmd)
            btx_pkg::CmdInsert: begin
              if ((nfree_q > (NB+1)'(btx_pkg::PoolNodes - KB)) ||
                  (root_cnt_q >= CB'(btx_pkg::MaxKeys))) begin
                st_d = btx_pkg::StNoRoom;
              end else begin
                root_cnt_d = root_cnt_q + CB'(1);
                cur_d.cnt = root_cnt_q + CB'(1);
                state_d = S_STEP;
              end
            end
            btx_pkg::CmdErase, btx_pkg::CmdCount: state_d = S_FSTEP;
            btx_pkg::CmdMax, btx_pkg::CmdMin: begin
              if (root_cnt_q == '0) st_d = btx_pkg::StEmpty;
              else state_d = S_XSTEP;
            end
            btx_pkg::CmdClear: begin
              nfree_d = (NB+1)'(1); root_l0_d = '0; root_l1_d = '0;
              root_cnt_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_FSTEP: begin
        if (lk_b == '0) begin
          if (cmd_q == btx_pkg::CmdErase) st_d = btx_pkg::StAbsent;
          state_d = S_DONE;
        end else begin
          mem_ra = lk_b; node_d = lk_b; leaf_d = (lvl_q == '0);
          if (lvl_q != '0) lvl_d = lvl_q - LB'(1);
          state_d = S_FLOAD;
        end
      end
      S_FLOAD: begin
        cur_d = rd_q;
        if (!leaf_q) begin
          state_d = S_FSTEP;
        end else if (cmd_q == btx_pkg::CmdCount) begin
          val_d = KB'(rd_q.cnt); state_d = S_DONE;
        end else if (rd_q.cnt == '0) begin
          st_d = btx_pkg::StAbsent; state_d = S_DONE;
        end else begin
          // key present: second walk decrements the path
          root_cnt_d = root_cnt_q - CB'(1);
          cur_d = '{l0: root_l0_q, l1: root_l1_q, cnt: root_cnt_q - CB'(1)};
          node_d = '0; lvl_d = LB'(KB - 1); leaf_d = 1'b0;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (lk_b == '0) begin
          nxt = nfree_q[NB-1:0];
          nfree_d = nfree_q + (NB+1)'(1);
          if (bit_k) wr_node.l1 = nxt;
          else wr_node.l0 = nxt;
          cur_d = '{l0: '0, l1: '0, cnt: CB'(1)};
          state_d = (lvl_q == '0) ? S_FIN : S_STEP;
        end else begin
          nxt = lk_b; mem_ra = lk_b;
          leaf_d = (lvl_q == '0);
          state_d = S_LOAD;
        end
        node_d = nxt;
        if (lvl_q != '0) lvl_d = lvl_q - LB'(1);
        if (node_q == '0) begin
          root_l0_d = wr_node.l0; root_l1_d = wr_node.l1;
        end else begin
          mem_we = 1'b1; mem_wa = node_q; mem_wd = wr_node;
        end
      end
      S_LOAD: begin
        cur_d = rd_q;
        cur_d.cnt = (cmd_q == btx_pkg::CmdInsert) ? rd_q.cnt + CB'(1)
                                                  : rd_q.cnt - CB'(1);
        state_d = leaf_q ? S_FIN : S_STEP;
      end
      S_FIN: begin
        mem_we = 1'b1; mem_wa = node_q; mem_wd = cur_q;
        state_d = S_DONE;
      end
      S_XSTEP: begin
        if (lk_p != '0) begin
          mem_ra = lk_p; node_d = lk_p; state_d = S_XCHK;
        end else begin
          mem_ra = lk_np; node_d = lk_np;
          if (cmd_q == btx_pkg::CmdMin) acc_d[lvl_q] = 1'b1;
          if (lvl_q == '0) begin
            val_d = acc_d; state_d = S_DONE;
          end else begin
            lvl_d = lvl_q - LB'(1); state_d = S_XLOAD;
          end
        end
      end
      S_XCHK: begin
        if (rd_q.cnt != '0) begin
          if (cmd_q == btx_pkg::CmdMax) acc_d[lvl_q] = 1'b1;
          if (lvl_q == '0) begin
            val_d = acc_d; state_d = S_DONE;
          end else begin
            cur_d = rd_q; lvl_d = lvl_q - LB'(1); state_d = S_XSTEP;
          end
        end else begin
          mem_ra = lk_np; node_d = lk_np;
          if (cmd_q == btx_pkg::CmdMin) acc_d[lvl_q] = 1'b1;
          if (lvl_q == '0) begin
            val_d = acc_d; state_d = S_DONE;
          end else begin
            lvl_d = lvl_q - LB'(1); state_d = S_XLOAD;
          end
        end
      end
      S_XLOAD: begin
        cur_d = rd_q;
        state_d = S_XSTEP;
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_load = 1'b1;
          rsp_d = '{value: val_q, stored_keys: root_cnt_q, status: st_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; nfree_q <= (NB+1)'(1);
      root_l0_q <= '0; root_l1_q <= '0; root_cnt_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; nfree_q <= nfree_d;
      root_l0_q <= root_l0_d; root_l1_q <= root_l1_d; root_cnt_q <= root_cnt_d;
      if (rsp_load) rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d; node_q <= node_d; cur_q <= cur_d; leaf_q <= leaf_d;
    acc_q <= acc_d; val_q <= val_d; st_q <= st_d;
    rsp_q <= rsp_d;
    if (req_valid_i && req_ready_o) begin
      cmd_q <= req_i.cmd; key_q <= req_i.key;
    end
  end

  `BTX_ASSERT_NEXT(a_rsp_hold, rsp_valid_o && !rsp_ready_i, rsp_valid_o && $stable(rsp_o), "rsp dropped")
  `BTX_ASSERT_NEXT(a_accept, req_valid_i && req_ready_o, state_q != S_IDLE, "no start")
  `BTX_ASSERT(a_nfree, nfree_q <= (NB+1)'(btx_pkg::PoolNodes), "pool overflow")
  `BTX_ASSERT(a_onehot, $onehot(state_q), "state not one-hot")
endmodule
